// ===== rtl/sas_pkg.sv =====
// Shared types and constants for the shell argument splitter.
// No dependencies; every other rtl file refers to this package by scoped names.
`default_nettype none

package sas_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_TAB       = 8'h09;

   typedef enum logic [2:0] {
      MODE_SPACES = 3'd0,
      MODE_ARG    = 3'd1,
      MODE_SQ     = 3'd2,
      MODE_DQ     = 3'd3,
      MODE_ESC    = 3'd4,
      MODE_ESC_DQ = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_END  = 2'd1,
      KIND_OK   = 2'd2,
      KIND_ERR  = 2'd3
   } kind_type;

   typedef enum logic {
      FUNC_CHAR = 1'b0,
      FUNC_EOL  = 1'b1
   } func_type;

   typedef struct packed {
      func_type   func;
      logic [7:0] ch;
   } req_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] out_char;
      logic       last;
   } rsp_type;

   // One or two results produced by a single input item.
   typedef struct packed {
      logic       two;
      kind_type   kind0;
      logic [7:0] char0;
      kind_type   kind1;
      logic [7:0] char1;
   } entry_type;

   function automatic logic is_space(input logic [7:0] c);
      is_space = (c == CHAR_SPACE) || (c == CHAR_NEWLINE) || (c == CHAR_TAB);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/shell_argument_splitter.sv =====
// Shell-style command line splitter. Ties front end, entry queue and back end.
// Depends on sas_pkg, sas_front, sas_queue and sas_back.
//
// Usage:
//   Input side is a queue: drive req_data (func, ch) and raise req_push while
//   req_full is low. func selects a line byte or the end-of-line marker.
//   Result side is a queue: while rsp_empty is low, rsp_data holds the oldest
//   result (kind, out_char, last); raise rsp_pop to take it.
//   Throughput: one input item per cycle while the entry queue has room. The
//   parse state advances in the cycle an item is accepted, so consecutive bytes
//   need no gaps. The result port delivers one result per cycle while rsp_pop
//   is high; items that give two results deliver them one after the other.
//   The entry queue loads an item's result at the accepting edge, and the
//   output register loads it from there, when nothing older is waiting.
//   Items that give no result (quotes, backslashes, extra spaces) leave nothing.
//   Stall: when rsp_pop stays low, the queue of QueueDepth entries fills and
//   req_full rises; nothing is lost.
//   Reset: synchronous; empties the queue and output and puts the parser back
//   between arguments.
`default_nettype none

module shell_argument_splitter #(
   parameter int unsigned QueueDepth = sas_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire sas_pkg::req_type req_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output sas_pkg::rsp_type      rsp_data
);

   logic               accept;
   logic               push;
   sas_pkg::entry_type push_entry;
   logic               head_valid;
   logic               head_pop;
   sas_pkg::entry_type head_entry;

   assign accept = req_push & ~req_full;

   sas_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .push   (push),
      .entry  (push_entry)
   );

   sas_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (req_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   sas_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .head_pop   (head_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/sas_front.sv =====
// Front end: parse state machine, classifies each item into zero, one or two results.
// Depends on sas_pkg.
`default_nettype none

module sas_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire sas_pkg::req_type   req,
   output logic                    push,
   output sas_pkg::entry_type      entry
);

   sas_pkg::mode_type mode_ff, mode_in;
   logic              has_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sas_pkg::MODE_SPACES;
      end else if (accept) begin
         mode_ff <= mode_in;
      end
   end

   // Next state
   always_comb begin
      mode_in = mode_ff;
      if (req.func == sas_pkg::FUNC_EOL) begin
         mode_in = sas_pkg::MODE_SPACES;
      end else begin
         case (mode_ff)
            sas_pkg::MODE_SQ: begin
               if (req.ch == sas_pkg::CHAR_SQUOTE) mode_in = sas_pkg::MODE_ARG;
            end
            sas_pkg::MODE_DQ: begin
               if (req.ch == sas_pkg::CHAR_DQUOTE) begin
                  mode_in = sas_pkg::MODE_ARG;
               end else if (req.ch == sas_pkg::CHAR_BACKSLASH) begin
                  mode_in = sas_pkg::MODE_ESC_DQ;
               end
            end
            sas_pkg::MODE_ESC:    mode_in = sas_pkg::MODE_ARG;
            sas_pkg::MODE_ESC_DQ: mode_in = sas_pkg::MODE_DQ;
            default: begin
               if (req.ch == sas_pkg::CHAR_DQUOTE) begin
                  mode_in = sas_pkg::MODE_DQ;
               end else if (req.ch == sas_pkg::CHAR_SQUOTE) begin
                  mode_in = sas_pkg::MODE_SQ;
               end else if (req.ch == sas_pkg::CHAR_BACKSLASH) begin
                  mode_in = sas_pkg::MODE_ESC;
               end else if (sas_pkg::is_space(req.ch)) begin
                  mode_in = sas_pkg::MODE_SPACES;
               end else begin
                  mode_in = sas_pkg::MODE_ARG;
               end
            end
         endcase
      end
   end

   // Outputs
   always_comb begin
      has_result  = 1'b0;
      entry       = '0;
      entry.kind0 = sas_pkg::KIND_BYTE;
      entry.kind1 = sas_pkg::KIND_BYTE;
      if (req.func == sas_pkg::FUNC_EOL) begin
         has_result = 1'b1;
         case (mode_ff)
            sas_pkg::MODE_ARG: begin
               entry.two   = 1'b1;
               entry.kind0 = sas_pkg::KIND_END;
               entry.kind1 = sas_pkg::KIND_OK;
            end
            sas_pkg::MODE_SQ, sas_pkg::MODE_DQ, sas_pkg::MODE_ESC,
            sas_pkg::MODE_ESC_DQ: begin
               entry.kind0 = sas_pkg::KIND_ERR;
            end
            default: entry.kind0 = sas_pkg::KIND_OK;
         endcase
      end else begin
         case (mode_ff)
            sas_pkg::MODE_SQ: begin
               if (req.ch != sas_pkg::CHAR_SQUOTE) begin
                  has_result  = 1'b1;
                  entry.char0 = req.ch;
               end
            end
            sas_pkg::MODE_DQ: begin
               if (req.ch != sas_pkg::CHAR_DQUOTE && req.ch != sas_pkg::CHAR_BACKSLASH) begin
                  has_result  = 1'b1;
                  entry.char0 = req.ch;
               end
            end
            sas_pkg::MODE_ESC: begin
               has_result  = 1'b1;
               entry.char0 = req.ch;
            end
            sas_pkg::MODE_ESC_DQ: begin
               has_result = 1'b1;
               // keep the backslash unless it escapes a quote or a backslash
               if (req.ch != sas_pkg::CHAR_DQUOTE && req.ch != sas_pkg::CHAR_BACKSLASH) begin
                  entry.two   = 1'b1;
                  entry.char0 = sas_pkg::CHAR_BACKSLASH;
                  entry.char1 = req.ch;
               end else begin
                  entry.char0 = req.ch;
               end
            end
            default: begin
               if (req.ch == sas_pkg::CHAR_DQUOTE || req.ch == sas_pkg::CHAR_SQUOTE ||
                   req.ch == sas_pkg::CHAR_BACKSLASH) begin
                  has_result = 1'b0;
               end else if (sas_pkg::is_space(req.ch)) begin
                  if (mode_ff == sas_pkg::MODE_ARG) begin
                     has_result  = 1'b1;
                     entry.kind0 = sas_pkg::KIND_END;
                  end
               end else begin
                  has_result  = 1'b1;
                  entry.char0 = req.ch;
               end
            end
         endcase
      end
   end

   assign push = accept & has_result;

endmodule

`default_nettype wire

// ===== rtl/sas_queue.sv =====
// Short register queue of result entries between front and back end.
// Depends on sas_pkg.
`default_nettype none

module sas_queue #(
   parameter int unsigned Depth = sas_pkg::QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire sas_pkg::entry_type push_entry,
   output logic                    full,
   input  wire logic               pop,
   output logic                    head_valid,
   output sas_pkg::entry_type      head_entry
);

   localparam int unsigned AddrWidth  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CountWidth = $clog2(Depth + 1);
   localparam logic [AddrWidth-1:0]  LastAddr  = AddrWidth'(Depth - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(Depth);

   sas_pkg::entry_type    slot_ff [Depth];
   logic [AddrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AddrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full       = (count_ff == FullCount);
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastAddr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastAddr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sas_back.sv =====
// Back end: output register that plays out one or two results per queued entry.
// Depends on sas_pkg.
`default_nettype none

module sas_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               head_valid,
   input  wire sas_pkg::entry_type head_entry,
   output logic                    head_pop,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output sas_pkg::rsp_type        rsp_data
);

   sas_pkg::entry_type entry_ff, entry_in;
   logic               valid_ff, valid_in;
   logic               phase_ff, phase_in;
   logic               take;

   // Take a new entry when the register is empty or its final result leaves.
   assign take     = ~valid_ff | (rsp_pop & (phase_ff | ~entry_ff.two));
   assign head_pop = take & head_valid;

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      phase_in = phase_ff;
      if (take) begin
         valid_in = head_valid;
         phase_in = 1'b0;
         entry_in = head_entry;
      end else if (rsp_pop) begin
         phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign rsp_empty         = ~valid_ff;
   assign rsp_data.kind     = phase_ff ? entry_ff.kind1 : entry_ff.kind0;
   assign rsp_data.out_char = phase_ff ? entry_ff.char1 : entry_ff.char0;
   assign rsp_data.last     = phase_ff | ~entry_ff.two;

endmodule

`default_nettype wire

// ===== sim/shell_argument_splitter_tb.sv =====
// Testbench for shell_argument_splitter: directed lines, then random lines under idle/stall phases.
// Results are checked against an in-bench parser model; depends on sas_pkg and the rtl top.
`timescale 1ns / 100ps

module shell_argument_splitter_tb;

   localparam int QUIET_LIMIT   = 4000;
   localparam int ITEMS_PER_RUN = 1350;
   localparam int HOLD_CYCLES   = 48;
   localparam int DRAIN_CYCLES  = 10;

   typedef struct {
      sas_pkg::req_type item;
      int               typed_cnt;   // -1: take the parser model's results
      sas_pkg::rsp_type t0;
      sas_pkg::rsp_type t1;
   } script_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_push = 1'b0;
   sas_pkg::req_type req_data = '0;
   logic             rsp_pop = 1'b0;
   logic             req_full;
   logic             rsp_empty;
   sas_pkg::rsp_type rsp_data;

   sas_pkg::mode_type parse_state = sas_pkg::MODE_SPACES;
   sas_pkg::rsp_type  pending_rsp[$];
   sas_pkg::req_type  line_buf[$];
   script_row_type    line_script[$];
   int                error_count = 0;
   int                idle_pct = 0;
   int                stall_pct = 0;
   int                hold_token = 0;
   int                hold_seen = 0;
   int                hold_left = 0;
   int                quiet_cycles = 0;

   shell_argument_splitter dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic add_row(input script_row_type r);
      line_script = {line_script, r};
   endtask

   task automatic add_item(input sas_pkg::req_type item);
      line_buf = {line_buf, item};
   endtask

   task automatic expect_rsp(input sas_pkg::rsp_type r);
      pending_rsp = {pending_rsp, r};
   endtask

   function automatic bit is_special(input logic [7:0] c);
      return c == sas_pkg::CHAR_DQUOTE || c == sas_pkg::CHAR_SQUOTE ||
             c == sas_pkg::CHAR_BACKSLASH || c == sas_pkg::CHAR_SPACE ||
             c == sas_pkg::CHAR_NEWLINE || c == sas_pkg::CHAR_TAB;
   endfunction

   // Advance the parse state by one item; return how many results it gives.
   function automatic int split_step(input sas_pkg::req_type item,
                                     output sas_pkg::rsp_type r0,
                                     output sas_pkg::rsp_type r1);
      sas_pkg::mode_type m;
      sas_pkg::kind_type k0, k1;
      logic [7:0]        c0, c1;
      int                n;
      m = parse_state;
      k0 = sas_pkg::KIND_BYTE;
      k1 = sas_pkg::KIND_BYTE;
      c0 = 8'h00;
      c1 = 8'h00;
      n = 0;
      if (item.func == sas_pkg::FUNC_EOL) begin
         case (m)
            sas_pkg::MODE_SPACES: begin
               k0 = sas_pkg::KIND_OK;
               n = 1;
            end
            sas_pkg::MODE_ARG: begin
               k0 = sas_pkg::KIND_END;
               k1 = sas_pkg::KIND_OK;
               n = 2;
            end
            default: begin
               k0 = sas_pkg::KIND_ERR;
               n = 1;
            end
         endcase
         m = sas_pkg::MODE_SPACES;
      end else begin
         case (m)
            sas_pkg::MODE_SQ: begin
               if (item.ch == sas_pkg::CHAR_SQUOTE) m = sas_pkg::MODE_ARG;
               else begin
                  c0 = item.ch;
                  n = 1;
               end
            end
            sas_pkg::MODE_DQ: begin
               if (item.ch == sas_pkg::CHAR_DQUOTE) m = sas_pkg::MODE_ARG;
               else if (item.ch == sas_pkg::CHAR_BACKSLASH) m = sas_pkg::MODE_ESC_DQ;
               else begin
                  c0 = item.ch;
                  n = 1;
               end
            end
            sas_pkg::MODE_ESC: begin
               c0 = item.ch;
               n = 1;
               m = sas_pkg::MODE_ARG;
            end
            sas_pkg::MODE_ESC_DQ: begin
               // keep the backslash unless it escapes a quote or a backslash
               if (item.ch != sas_pkg::CHAR_DQUOTE &&
                   item.ch != sas_pkg::CHAR_BACKSLASH) begin
                  c0 = sas_pkg::CHAR_BACKSLASH;
                  c1 = item.ch;
                  n = 2;
               end else begin
                  c0 = item.ch;
                  n = 1;
               end
               m = sas_pkg::MODE_DQ;
            end
            default: begin
               if (item.ch == sas_pkg::CHAR_DQUOTE) m = sas_pkg::MODE_DQ;
               else if (item.ch == sas_pkg::CHAR_SQUOTE) m = sas_pkg::MODE_SQ;
               else if (item.ch == sas_pkg::CHAR_BACKSLASH) m = sas_pkg::MODE_ESC;
               else if (item.ch == sas_pkg::CHAR_SPACE || item.ch == sas_pkg::CHAR_NEWLINE ||
                        item.ch == sas_pkg::CHAR_TAB) begin
                  if (m == sas_pkg::MODE_ARG) begin
                     k0 = sas_pkg::KIND_END;
                     n = 1;
                  end
                  m = sas_pkg::MODE_SPACES;
               end else begin
                  c0 = item.ch;
                  n = 1;
                  m = sas_pkg::MODE_ARG;
               end
            end
         endcase
      end
      parse_state = m;
      r0 = '{kind: k0, out_char: c0, last: (n == 1)};
      r1 = '{kind: k1, out_char: c1, last: 1'b1};
      return n;
   endfunction

   function automatic sas_pkg::req_type byte_item(input logic [7:0] c);
      return '{func: sas_pkg::FUNC_CHAR, ch: c};
   endfunction

   function automatic sas_pkg::req_type eol_item(input logic [7:0] c);
      return '{func: sas_pkg::FUNC_EOL, ch: c};
   endfunction

   function automatic logic [7:0] any_char();
      if ($urandom_range(99) < 35) begin
         case ($urandom_range(5))
            0: return sas_pkg::CHAR_DQUOTE;
            1: return sas_pkg::CHAR_SQUOTE;
            2: return sas_pkg::CHAR_BACKSLASH;
            3: return sas_pkg::CHAR_SPACE;
            4: return sas_pkg::CHAR_NEWLINE;
            default: return sas_pkg::CHAR_TAB;
         endcase
      end
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (is_special(c));
      return c;
   endfunction

   function automatic logic [7:0] blank_char();
      case ($urandom_range(2))
         0: return sas_pkg::CHAR_SPACE;
         1: return sas_pkg::CHAR_NEWLINE;
         default: return sas_pkg::CHAR_TAB;
      endcase
   endfunction

   function automatic script_row_type row(input sas_pkg::func_type f, input logic [7:0] c,
                                          input int cnt,
                                          input sas_pkg::kind_type k0 = sas_pkg::KIND_BYTE,
                                          input logic [7:0] c0 = 8'h00,
                                          input sas_pkg::kind_type k1 = sas_pkg::KIND_BYTE,
                                          input logic [7:0] c1 = 8'h00);
      script_row_type r;
      r.item = '{func: f, ch: c};
      r.typed_cnt = cnt;
      r.t0 = '{kind: k0, out_char: c0, last: (cnt == 1)};
      r.t1 = '{kind: k1, out_char: c1, last: 1'b1};
      return r;
   endfunction

   // Mostly well-formed lines with random words, quotes and escapes; the rest is noise.
   task automatic build_line();
      int          seg;
      logic [7:0]  c;
      line_buf.delete();
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(1, 12)) add_item(byte_item(any_char()));
      end else begin
         if ($urandom_range(1)) add_item(byte_item(blank_char()));
         repeat ($urandom_range(0, 4)) begin
            repeat ($urandom_range(1, 3)) begin
               seg = $urandom_range(3);
               case (seg)
                  0: repeat ($urandom_range(1, 4)) add_item(byte_item(plain_char()));
                  1: begin
                     add_item(byte_item(sas_pkg::CHAR_SQUOTE));
                     repeat ($urandom_range(0, 4)) begin
                        do c = any_char(); while (c == sas_pkg::CHAR_SQUOTE);
                        add_item(byte_item(c));
                     end
                     add_item(byte_item(sas_pkg::CHAR_SQUOTE));
                  end
                  2: begin
                     add_item(byte_item(sas_pkg::CHAR_DQUOTE));
                     repeat ($urandom_range(0, 4)) begin
                        c = any_char();
                        if (c == sas_pkg::CHAR_DQUOTE || c == sas_pkg::CHAR_BACKSLASH) begin
                           add_item(byte_item(sas_pkg::CHAR_BACKSLASH));
                           add_item(byte_item(any_char()));
                        end else add_item(byte_item(c));
                     end
                     add_item(byte_item(sas_pkg::CHAR_DQUOTE));
                  end
                  default: begin
                     add_item(byte_item(sas_pkg::CHAR_BACKSLASH));
                     add_item(byte_item(any_char()));
                  end
               endcase
            end
            repeat ($urandom_range(1, 2)) add_item(byte_item(blank_char()));
         end
      end
      if ($urandom_range(9) != 0) add_item(eol_item(8'($urandom_range(255))));
   endtask

   // Hold push until the item is taken; push stays high for the next item.
   task automatic offer_item(input sas_pkg::req_type item);
      while ($urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic send_row(input script_row_type r);
      sas_pkg::rsp_type p0, p1;
      int               n;
      offer_item(r.item);
      n = split_step(r.item, p0, p1);
      if (r.typed_cnt >= 0) begin
         n = r.typed_cnt;
         p0 = r.t0;
         p1 = r.t1;
      end
      if (n >= 1) expect_rsp(p0);
      if (n == 2) expect_rsp(p1);
   endtask

   task automatic drain_pending();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : check_results
      sas_pkg::rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_rsp.size() == 0) begin
            flag_mismatch($sformatf("unexpected item kind=%0d char=%02h last=%0b",
                                    rsp_data.kind, rsp_data.out_char, rsp_data.last));
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.kind !== want.kind)
               flag_mismatch($sformatf("kind %0d, want %0d", rsp_data.kind, want.kind));
            if (rsp_data.out_char !== want.out_char)
               flag_mismatch($sformatf("out_char %02h, want %02h",
                                       rsp_data.out_char, want.out_char));
            if (rsp_data.last !== want.last)
               flag_mismatch($sformatf("last %0b, want %0b", rsp_data.last, want.last));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int sent;
      int target;
      add_row(row(sas_pkg::FUNC_EOL, 8'hFF, 1, sas_pkg::KIND_OK));
      add_row(row(sas_pkg::FUNC_CHAR, 8'h00, 1, sas_pkg::KIND_BYTE, 8'h00));
      add_row(row(sas_pkg::FUNC_CHAR, 8'hFF, 1, sas_pkg::KIND_BYTE, 8'hFF));
      add_row(row(sas_pkg::FUNC_CHAR, sas_pkg::CHAR_SPACE, 1, sas_pkg::KIND_END));
      add_row(row(sas_pkg::FUNC_CHAR, sas_pkg::CHAR_TAB, 0));
      add_row(row(sas_pkg::FUNC_CHAR, sas_pkg::CHAR_SQUOTE, -1));
      add_row(row(sas_pkg::FUNC_CHAR, sas_pkg::CHAR_DQUOTE, -1));
      add_row(row(sas_pkg::FUNC_CHAR, sas_pkg::CHAR_BACKSLASH, -1));
      add_row(row(sas_pkg::FUNC_CHAR, sas_pkg::CHAR_SQUOTE, -1));
      add_row(row(sas_pkg::FUNC_CHAR, sas_pkg::CHAR_DQUOTE, -1));
      add_row(row(sas_pkg::FUNC_CHAR, sas_pkg::CHAR_BACKSLASH, -1));
      add_row(row(sas_pkg::FUNC_CHAR, 8'h78, -1));
      add_row(row(sas_pkg::FUNC_CHAR, sas_pkg::CHAR_BACKSLASH, -1));
      add_row(row(sas_pkg::FUNC_CHAR, sas_pkg::CHAR_DQUOTE, -1));
      add_row(row(sas_pkg::FUNC_CHAR, sas_pkg::CHAR_DQUOTE, -1));
      add_row(row(sas_pkg::FUNC_EOL, 8'h00, 2, sas_pkg::KIND_END, 8'h00, sas_pkg::KIND_OK));
      add_row(row(sas_pkg::FUNC_CHAR, sas_pkg::CHAR_DQUOTE, -1));
      add_row(row(sas_pkg::FUNC_CHAR, sas_pkg::CHAR_DQUOTE, -1));
      add_row(row(sas_pkg::FUNC_CHAR, sas_pkg::CHAR_NEWLINE, 1, sas_pkg::KIND_END));
      add_row(row(sas_pkg::FUNC_CHAR, sas_pkg::CHAR_BACKSLASH, -1));
      add_row(row(sas_pkg::FUNC_CHAR, sas_pkg::CHAR_SPACE, -1));
      add_row(row(sas_pkg::FUNC_EOL, 8'h5A, -1));
      add_row(row(sas_pkg::FUNC_CHAR, sas_pkg::CHAR_SQUOTE, 0));
      add_row(row(sas_pkg::FUNC_EOL, 8'h00, 1, sas_pkg::KIND_ERR));
      add_row(row(sas_pkg::FUNC_CHAR, sas_pkg::CHAR_BACKSLASH, 0));
      add_row(row(sas_pkg::FUNC_EOL, 8'h00, 1, sas_pkg::KIND_ERR));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (line_script[i]) send_row(line_script[i]);
      drain_pending();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct = 72;
               stall_pct = 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct = 72;
            end
            default: begin
               idle_pct = 37;
               stall_pct = 37;
            end
         endcase
         // starve the result side so the queue fills and the input stalls
         if (phase == 0 || phase == 2) hold_token++;
         sent = 0;
         target = ITEMS_PER_RUN / 4;
         while (sent < target) begin
            build_line();
            foreach (line_buf[i]) send_row(row(line_buf[i].func, line_buf[i].ch, -1));
            sent += line_buf.size();
         end
         drain_pending();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
